// ----- rtl/fcw_pkg.sv -----
// Shared constants and types for the filtered crest window block.
`timescale 1ns / 1ps
package fcw_pkg;

  // Window and arithmetic constants.
  localparam int WindowLen  = 12;
  localparam int CountW     = 4;
  localparam int SampleW    = 16;
  localparam int MagW       = 15;
  localparam int SumW       = 20;
  localparam int AbsSumW    = 19;
  localparam int CrestShift = 3;
  localparam int ScaledW    = MagW + CrestShift;
  localparam int RoundAdd   = 5;
  localparam int ResultW    = 30;
  localparam int QuotW      = 15;

  // Division by ten as a multiply by ceil(2^21 / 10); exact for inputs below 2^18.
  localparam int RecipShift = 21;
  localparam int RecipMul   = 209716;
  localparam int ProdW      = 2 * ScaledW;

  // Queue between the window front end and the result back end.
  localparam int QueueDepth = 4;
  localparam int QueueAddrW = $clog2(QueueDepth);

  // Summary of one completed window.
  typedef struct packed {
    logic [MagW-1:0]        peak_magnitude;
    logic                   peak_positive;
    logic signed [SumW-1:0] window_sum;
  } window_rec_t;

endpackage

// ----- rtl/fcw_if.sv -----
// Valid/ready channel interfaces for samples and results.
`timescale 1ns / 1ps
interface fcw_sample_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink (input valid, input sample, output ready);
endinterface

interface fcw_result_if;
  logic        valid;
  logic        ready;
  logic [29:0] crest_squared;

  modport source (output valid, output crest_squared, input ready);
  modport sink (input valid, input crest_squared, output ready);
endinterface

// ----- rtl/fcw_front.sv -----
// Front end: accepts samples and tracks crest and sum over each window.
`timescale 1ns / 1ps
module fcw_front (
  input  logic                clk,
  input  logic                rst,
  fcw_sample_if.sink          samples,
  input  logic                full,
  output logic                push,
  output fcw_pkg::window_rec_t rec
);
  import fcw_pkg::*;

  localparam logic [CountW-1:0] LastCount = CountW'(WindowLen - 1);

  logic [CountW-1:0]      sample_count;
  logic [MagW-1:0]        peak_magnitude;
  logic                   peak_positive;
  logic signed [SumW-1:0] window_sum;

  logic                   accept;
  logic                   last;
  logic [SampleW-1:0]     abs_full;
  logic [MagW-1:0]        mag;
  logic                   take_peak;
  logic [MagW-1:0]        peak_magnitude_next;
  logic                   peak_positive_next;
  logic signed [SumW-1:0] window_sum_next;

  // A beat is taken whenever the queue has room for a window record.
  assign samples.ready = !full;
  assign accept        = samples.valid && samples.ready;
  assign last          = (sample_count == LastCount);

  // Magnitude of the sample; the most negative code saturates.
  always_comb begin
    abs_full  = samples.sample[SampleW-1] ? SampleW'(-samples.sample) : samples.sample;
    mag       = abs_full[SampleW-1] ? {MagW{1'b1}} : abs_full[MagW-1:0];
    take_peak = (mag > peak_magnitude);
    peak_magnitude_next = take_peak ? mag : peak_magnitude;
    peak_positive_next  = take_peak ? !samples.sample[SampleW-1] : peak_positive;
    window_sum_next     = window_sum + SumW'(samples.sample);
  end

  // The twelfth beat hands the finished window to the queue.
  assign push               = accept && last;
  assign rec.peak_magnitude = peak_magnitude_next;
  assign rec.peak_positive  = peak_positive_next;
  assign rec.window_sum     = window_sum_next;

  // Window state, cleared after each completed window.
  always_ff @(posedge clk) begin
    if (rst) begin
      sample_count   <= '0;
      peak_magnitude <= '0;
      peak_positive  <= 1'b1;
      window_sum     <= '0;
    end else if (accept) begin
      if (last) begin
        sample_count   <= '0;
        peak_magnitude <= '0;
        peak_positive  <= 1'b1;
        window_sum     <= '0;
      end else begin
        sample_count   <= sample_count + 1'b1;
        peak_magnitude <= peak_magnitude_next;
        peak_positive  <= peak_positive_next;
        window_sum     <= window_sum_next;
      end
    end
  end

  // The count never passes the last position of a window.
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    sample_count <= LastCount)
    else $error("sample count beyond window");

endmodule

// ----- rtl/fcw_queue.sv -----
// Short queue of completed window records between front and back ends.
`timescale 1ns / 1ps
module fcw_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  fcw_pkg::window_rec_t push_rec,
  input  logic                 pop,
  output fcw_pkg::window_rec_t pop_rec,
  output logic                 full,
  output logic                 avail
);
  import fcw_pkg::*;

  localparam logic [QueueAddrW:0] DepthCount = (QueueAddrW + 1)'(QueueDepth);

  window_rec_t           entries [QueueDepth];
  logic [QueueAddrW-1:0] wr_ptr;
  logic [QueueAddrW-1:0] rd_ptr;
  logic [QueueAddrW:0]   count;

  assign full    = (count == DepthCount);
  assign avail   = (count != '0);
  assign pop_rec = entries[rd_ptr];

  // Record storage.
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_rec;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= DepthCount)
    else $error("queue count overflow");

  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    !(push && full))
    else $error("push into full queue");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    !(pop && !avail))
    else $error("pop from empty queue");

endmodule

// ----- rtl/fcw_back.sv -----
// Back end: filters the window sum, scales, divides by ten and squares.
`timescale 1ns / 1ps
module fcw_back (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 avail,
  input  fcw_pkg::window_rec_t rec,
  output logic                 pop,
  fcw_result_if.source         results
);
  import fcw_pkg::*;

  logic                      advance;
  logic signed [SumW-1:0]    filt_sum;
  logic [AbsSumW-1:0]        abs_sum;
  logic signed [SumW:0]      diff;
  logic [ScaledW-1:0]        x_next;
  logic [ProdW-1:0]          prod;

  logic                      s1_valid;
  logic [ScaledW-1:0]        s1_x;
  logic                      s2_valid;
  logic [QuotW-1:0]          s2_q;
  logic                      out_valid;
  logic [ResultW-1:0]        out_sq;

  // The whole pipeline moves when the output register is free.
  assign advance = !out_valid || results.ready;
  assign pop     = advance && avail;

  // Sum zeroed when its sign opposes the crest; scaled crest less the sum magnitude, clamped, rounded.
  always_comb begin
    filt_sum = rec.window_sum;
    if (rec.peak_positive && rec.window_sum < 0) begin
      filt_sum = '0;
    end else if (!rec.peak_positive && rec.window_sum > 0) begin
      filt_sum = '0;
    end
    abs_sum = filt_sum[SumW-1] ? AbsSumW'(-filt_sum) : filt_sum[AbsSumW-1:0];
    diff    = $signed({3'b000, rec.peak_magnitude, {CrestShift{1'b0}}})
            - $signed({2'b00, abs_sum});
    x_next  = diff[SumW] ? '0 : diff[ScaledW-1:0] + ScaledW'(RoundAdd);
  end

  // Reciprocal multiply for the division by ten.
  assign prod = s1_x * ScaledW'(RecipMul);

  // Payload stages.
  always_ff @(posedge clk) begin
    if (advance) begin
      s1_x   <= x_next;
      s2_q   <= prod[RecipShift +: QuotW];
      out_sq <= ResultW'(s2_q) * ResultW'(s2_q);
    end
  end

  // Stage valid flags.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else if (advance) begin
      s1_valid  <= avail;
      s2_valid  <= s1_valid;
      out_valid <= s2_valid;
    end
  end

  assign results.valid         = out_valid;
  assign results.crest_squared = out_sq;

  // A pending result never drains the pipeline behind it.
  a_hold_stall: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !results.ready) |=> (out_valid && $stable(s1_valid) && $stable(s2_valid)))
    else $error("pipeline moved during stall");

  // Popping only happens while the pipeline advances.
  a_pop_advance: assert property (@(posedge clk) disable iff (rst)
    pop |-> (avail && advance))
    else $error("pop without advance");

endmodule

// ----- rtl/filtered_crest_window.sv -----
// Top level of the filtered crest window block.
`timescale 1ns / 1ps
//
//  Channel  | Role   | Payload                 | Beat
//  ---------+--------+-------------------------+------------------------------
//  samples  | sink   | sample, 16 bit signed   | one sample
//  results  | source | crest_squared, 30 bit   | one result per 12 samples
//
//  A sample is taken every cycle while the window queue has room.
//  A result is written to the queue by the edge that takes the twelfth sample
//  of its window, then passes the scale stage, reciprocal multiply and square
//  registers in turn. Results leave one per cycle at most.
//  Reset is synchronous: the window restarts and queue and pipeline empty.
//  A stalled result holds the back end; the front end keeps taking samples
//  until four windows wait in the queue.
module filtered_crest_window (
  input  logic         clk,
  input  logic         rst,
  fcw_sample_if.sink   samples,
  fcw_result_if.source results
);
  import fcw_pkg::*;

  window_rec_t push_rec;
  window_rec_t pop_rec;
  logic        push;
  logic        pop;
  logic        full;
  logic        avail;

  fcw_front u_front (
    .clk     (clk),
    .rst     (rst),
    .samples (samples),
    .full    (full),
    .push    (push),
    .rec     (push_rec)
  );

  fcw_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_rec (push_rec),
    .pop      (pop),
    .pop_rec  (pop_rec),
    .full     (full),
    .avail    (avail)
  );

  fcw_back u_back (
    .clk     (clk),
    .rst     (rst),
    .avail   (avail),
    .rec     (pop_rec),
    .pop     (pop),
    .results (results)
  );

endmodule
